FILE: rtl/mtbl_pkg.sv
package mtbl_pkg;

    localparam int NUM_BUCKETS = 1024;

    localparam int BIT_W  = 5;
    localparam int WORD_W = 2 ** BIT_W;
    localparam int WORDS  = (NUM_BUCKETS + WORD_W - 1) / WORD_W;
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WCNT   = 2 ** WIDX_W;
    localparam int ADDR_W = WIDX_W + BIT_W;
    localparam int MEM_D  = 2 ** ADDR_W;

    localparam int FUNC_W   = 3;
    localparam int ID_W     = 10;
    localparam int VAL_W    = 16;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 32;

    localparam logic [FUNC_W-1:0] FN_TICK    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_CREATE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FETCH   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_GIVE    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BLOCK  = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNUSED = 2'd3;

    typedef struct packed {
        logic latch;
        logic rd;
        logic exec;
        logic tick_rd;
        logic tick_wr;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic in_tick;
        logic tick_last;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: rtl/multi_token_bucket_limiter_core.sv
// Table of NUM_BUCKETS token buckets driven by one command per input beat and
// answering with exactly one result beat per command. Fetch, give back, create,
// release and unknown commands step through accept, memory read, update/write
// back and output load, the last of which waits for a free output register; a
// tick is accepted, walks every slot with a read and then a write back of each
// slot in the token store, and then loads its result. One command is in flight
// at a time; the next is accepted once the previous result has been loaded into
// the output register, even while that result still waits for m_tready. Live
// bits sit in 32-slot words with a per-word valid flag and a per-word full flag,
// so reset takes effect at once with no clearing pass, and create finds the
// lowest free slot in one read of a word.
module multi_token_bucket_limiter_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // func[2:0], bucket_id[12:3], refill_rate[28:13], burst_limit[44:29],
    // amount[60:45]
    input  logic [mtbl_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], slot_out[11:2], granted[27:12]
    output logic [mtbl_pkg::M_DATA_W-1:0] m_tdata
);

    mtbl_pkg::dp_cmd_t  cmd;
    mtbl_pkg::dp_stat_t stat;

    mtbl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mtbl_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while previous one in flight");

    a_full_no_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == mtbl_pkg::ST_FULL) |-> (m_tdata[27:2] == '0))
        else $error("table full result carries slot or grant");

    a_refused_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tdata[1:0] == mtbl_pkg::ST_BLOCK) ||
                     (m_tdata[1:0] == mtbl_pkg::ST_UNUSED)) |-> (m_tdata[27:12] == '0))
        else $error("refused command granted tokens");

    a_load_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result overwrote an untaken beat");
`endif

endmodule

FILE: rtl/mtbl_ctrl.sv
module mtbl_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  mtbl_pkg::dp_stat_t stat,
    output mtbl_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_TRD  = 3'd3;
    localparam logic [2:0] S_TWR  = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = stat.in_tick ? S_TRD : S_READ;
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_RESP;
            end
            S_TRD: begin
                cmd.tick_rd = 1'b1;
                state_next  = S_TWR;
            end
            S_TWR: begin
                cmd.tick_wr = 1'b1;
                state_next  = stat.tick_last ? S_RESP : S_TRD;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/mtbl_dpath.sv
module mtbl_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [mtbl_pkg::S_DATA_W-1:0]       s_tdata,
    input  mtbl_pkg::dp_cmd_t                   cmd,
    output mtbl_pkg::dp_stat_t                  stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mtbl_pkg::M_DATA_W-1:0]       m_tdata
);

    localparam int FUNC_W = mtbl_pkg::FUNC_W;
    localparam int ID_W   = mtbl_pkg::ID_W;
    localparam int VAL_W  = mtbl_pkg::VAL_W;
    localparam int STAT_W = mtbl_pkg::STAT_W;
    localparam int BIT_W  = mtbl_pkg::BIT_W;
    localparam int WORD_W = mtbl_pkg::WORD_W;
    localparam int WIDX_W = mtbl_pkg::WIDX_W;
    localparam int WCNT   = mtbl_pkg::WCNT;
    localparam int ADDR_W = mtbl_pkg::ADDR_W;
    localparam int MEM_D  = mtbl_pkg::MEM_D;
    localparam int RES_W  = STAT_W + ID_W + VAL_W;

    // Slots at or beyond NUM_BUCKETS read as occupied.
    function automatic logic [WORD_W-1:0] pad_mask(input logic [WIDX_W-1:0] w);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < WORD_W; b++) begin
            m[b] = (32'({w, BIT_W'(b)}) >= 32'(mtbl_pkg::NUM_BUCKETS));
        end
        return m;
    endfunction

    function automatic logic [WCNT-1:0] full_init();
        logic [WCNT-1:0] f;
        f = '0;
        for (int w = 0; w < WCNT; w++) begin
            f[w] = (w >= mtbl_pkg::WORDS);
        end
        return f;
    endfunction

    localparam logic [WCNT-1:0] FULL_INIT = full_init();

    logic [FUNC_W-1:0] func_reg;
    logic [ID_W-1:0]   id_reg;
    logic [VAL_W-1:0]  rate_reg;
    logic [VAL_W-1:0]  burst_reg;
    logic [VAL_W-1:0]  amount_reg;
    logic [ADDR_W-1:0] tick_idx_reg;

    logic [WCNT-1:0]   full_reg;
    logic [WCNT-1:0]   rowv_reg;

    logic [WORD_W-1:0]  live_mem [WCNT];
    logic [VAL_W-1:0]   tok_mem  [MEM_D];
    logic [2*VAL_W-1:0] par_mem  [MEM_D];

    logic [WORD_W-1:0]  live_rd_reg;
    logic               rv_rd_reg;
    logic [VAL_W-1:0]   tok_rd_reg;
    logic [2*VAL_W-1:0] par_rd_reg;
    logic [WIDX_W-1:0]  free_word_reg;
    logic               any_free_reg;

    logic [RES_W-1:0]    res_reg;
    logic                m_tvalid_reg;
    logic [RES_W-1:0]    m_res_reg;

    logic [WIDX_W-1:0] free_word;
    logic              any_free;
    logic [ADDR_W-1:0] id_slot;
    logic              id_ok;
    logic              rd_en;
    logic [WIDX_W-1:0] lw_raddr;
    logic [ADDR_W-1:0] ts_raddr;

    logic [WORD_W-1:0] eff_word;
    logic [WORD_W-1:0] pad;
    logic [WORD_W-1:0] occ;
    logic [BIT_W-1:0]  new_bit;
    logic [WORD_W-1:0] new_word;
    logic              new_full;
    logic [ADDR_W-1:0] new_slot;
    logic              id_live;

    logic [VAL_W-1:0]  cur_tok;
    logic [VAL_W-1:0]  cur_rate;
    logic [VAL_W-1:0]  cur_cap;
    logic [VAL_W-1:0]  add_val;
    logic [VAL_W:0]    sum;
    logic [VAL_W-1:0]  capped;
    logic [VAL_W-1:0]  grant;

    logic [STAT_W-1:0] res_status;
    logic [ID_W-1:0]   res_slot;
    logic [VAL_W-1:0]  res_grant;

    logic               lw_we;
    logic [WIDX_W-1:0]  lw_waddr;
    logic [WORD_W-1:0]  lw_wdata;
    logic               tok_we;
    logic [ADDR_W-1:0]  tok_waddr;
    logic [VAL_W-1:0]   tok_wdata;
    logic               par_we;
    logic               full_we;
    logic [WIDX_W-1:0]  full_waddr;
    logic               full_wdata;
    logic               res_load;

    assign stat.in_tick   = (s_tdata[FUNC_W-1:0] == mtbl_pkg::FN_TICK);
    assign stat.tick_last = (32'(tick_idx_reg) == 32'(mtbl_pkg::NUM_BUCKETS - 1));
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            func_reg   <= s_tdata[2:0];
            id_reg     <= s_tdata[12:3];
            rate_reg   <= s_tdata[28:13];
            burst_reg  <= s_tdata[44:29];
            amount_reg <= s_tdata[60:45];
        end
        if (cmd.rd) begin
            free_word_reg <= free_word;
            any_free_reg  <= any_free;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_idx_reg <= '0;
        end else if (cmd.latch) begin
            tick_idx_reg <= '0;
        end else if (cmd.tick_wr) begin
            tick_idx_reg <= tick_idx_reg + ADDR_W'(1);
        end
    end

    always_comb begin
        any_free  = 1'b0;
        free_word = '0;
        for (int w = WCNT - 1; w >= 0; w--) begin
            if (!full_reg[w]) begin
                any_free  = 1'b1;
                free_word = WIDX_W'(w);
            end
        end
    end

    assign id_slot  = ADDR_W'(id_reg);
    assign id_ok    = (32'(id_reg) < 32'(mtbl_pkg::NUM_BUCKETS));
    assign rd_en    = cmd.rd || cmd.tick_rd;
    assign lw_raddr = cmd.tick_rd ? tick_idx_reg[ADDR_W-1:BIT_W] :
                      (func_reg == mtbl_pkg::FN_CREATE) ? free_word :
                      id_slot[ADDR_W-1:BIT_W];
    assign ts_raddr = cmd.tick_rd ? tick_idx_reg : id_slot;

    always_ff @(posedge aclk) begin
        if (lw_we) begin
            live_mem[lw_waddr] <= lw_wdata;
        end
        if (rd_en) begin
            live_rd_reg <= live_mem[lw_raddr];
            rv_rd_reg   <= rowv_reg[lw_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_we) begin
            tok_mem[tok_waddr] <= tok_wdata;
        end
        if (rd_en) begin
            tok_rd_reg <= tok_mem[ts_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (par_we) begin
            par_mem[tok_waddr] <= {burst_reg, rate_reg};
        end
        if (rd_en) begin
            par_rd_reg <= par_mem[ts_raddr];
        end
    end

    assign eff_word = rv_rd_reg ? live_rd_reg : '0;
    assign pad      = pad_mask(free_word_reg);
    assign occ      = eff_word | pad;

    always_comb begin
        new_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!occ[b]) begin
                new_bit = BIT_W'(b);
            end
        end
    end

    assign new_word = eff_word | (WORD_W'(1) << new_bit);
    assign new_full = &(new_word | pad);
    assign new_slot = {free_word_reg, new_bit};
    assign id_live  = id_ok && eff_word[id_slot[BIT_W-1:0]];

    assign cur_tok  = tok_rd_reg;
    assign cur_rate = par_rd_reg[VAL_W-1:0];
    assign cur_cap  = par_rd_reg[2*VAL_W-1:VAL_W];
    assign add_val  = cmd.tick_wr ? cur_rate : amount_reg;
    assign sum      = {1'b0, cur_tok} + {1'b0, add_val};
    assign capped   = (sum > {1'b0, cur_cap}) ? cur_cap : sum[VAL_W-1:0];
    assign grant    = (cur_tok < amount_reg) ? cur_tok : amount_reg;

    always_comb begin
        res_status = mtbl_pkg::ST_OK;
        res_slot   = id_reg;
        res_grant  = '0;
        lw_we      = 1'b0;
        lw_waddr   = id_slot[ADDR_W-1:BIT_W];
        lw_wdata   = eff_word;
        tok_we     = 1'b0;
        tok_waddr  = id_slot;
        tok_wdata  = capped;
        par_we     = 1'b0;
        full_we    = 1'b0;
        full_waddr = id_slot[ADDR_W-1:BIT_W];
        full_wdata = 1'b0;
        case (func_reg)
            mtbl_pkg::FN_TICK: begin
                res_slot  = '0;
                tok_we    = cmd.tick_wr && eff_word[tick_idx_reg[BIT_W-1:0]];
                tok_waddr = tick_idx_reg;
            end
            mtbl_pkg::FN_CREATE: begin
                if (any_free_reg) begin
                    res_slot   = ID_W'(new_slot);
                    lw_we      = cmd.exec;
                    lw_waddr   = free_word_reg;
                    lw_wdata   = new_word;
                    tok_we     = cmd.exec;
                    tok_waddr  = new_slot;
                    tok_wdata  = '0;
                    par_we     = cmd.exec;
                    full_we    = cmd.exec;
                    full_waddr = free_word_reg;
                    full_wdata = new_full;
                end else begin
                    res_status = mtbl_pkg::ST_FULL;
                    res_slot   = '0;
                end
            end
            mtbl_pkg::FN_FETCH: begin
                if (!id_live) begin
                    res_status = mtbl_pkg::ST_UNUSED;
                end else if (cur_tok == '0) begin
                    res_status = mtbl_pkg::ST_BLOCK;
                end else begin
                    res_grant = grant;
                    tok_we    = cmd.exec;
                    tok_wdata = cur_tok - grant;
                end
            end
            mtbl_pkg::FN_GIVE: begin
                if (!id_live) begin
                    res_status = mtbl_pkg::ST_UNUSED;
                end else begin
                    res_grant = amount_reg;
                    tok_we    = cmd.exec;
                end
            end
            mtbl_pkg::FN_RELEASE: begin
                if (!id_live) begin
                    res_status = mtbl_pkg::ST_UNUSED;
                end else begin
                    lw_we    = cmd.exec;
                    lw_wdata = eff_word & ~(WORD_W'(1) << id_slot[BIT_W-1:0]);
                    full_we  = cmd.exec;
                end
            end
            default: begin
                res_status = mtbl_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= FULL_INIT;
            rowv_reg <= '0;
        end else begin
            if (full_we) begin
                full_reg[full_waddr] <= full_wdata;
            end
            if (lw_we) begin
                rowv_reg[lw_waddr] <= 1'b1;
            end
        end
    end

    assign res_load = cmd.exec || (cmd.tick_wr && stat.tick_last);

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= {res_grant, res_slot, res_status};
        end
        if (cmd.out_load) begin
            m_res_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(mtbl_pkg::M_DATA_W - RES_W){1'b0}}, m_res_reg};

endmodule
